[sv/aae_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aae_pkg
// Shared types and constants of the adaptive arithmetic encoder.
// ----------------------------------------------------------------------------
package aae_pkg;

  // model count width and configuration
  localparam int COUNT_W = 14;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 14'd16383;

  // pending follow count width (holds the largest follow limit)
  localparam int FOLLOW_W = 9;

  // result buffer for the code bytes of one item
  localparam int RES_DEPTH = 64;
  localparam int RES_AW = 6;

  // parameter defaults
  localparam int CODE_BITS_DEF = 16;
  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int FOLLOW_MAX_DEF = 448;

  // datapath operations, one per cycle
  typedef enum logic [5:0] {
    OP_NOP,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_ACCEPT,
    OP_RANK,
    OP_GET_TOT,
    OP_GET_HI,
    OP_GET_LO,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_DIV,
    OP_SAVE_HI,
    OP_BOUNDS,
    OP_RN,
    OP_FOLLOW,
    OP_END_ADD,
    OP_END_BIT,
    OP_END_EMIT,
    OP_HV_INIT,
    OP_HV_RD,
    OP_HV_WR,
    OP_SR_INIT,
    OP_SR_V,
    OP_SR_RD,
    OP_SR_CMP,
    OP_SW_RD_I,
    OP_SW_RD_R,
    OP_SW_W1,
    OP_SW_W2,
    OP_INC,
    OP_CI_RD,
    OP_CI_WR,
    OP_DR_INIT,
    OP_DR_RD,
    OP_DR_LOAD
  } op_t;

  // renormalization decision
  typedef enum logic [1:0] {
    RN_LOW,
    RN_HIGH,
    RN_MID,
    RN_STOP
  } rn_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic idx_zero;
    logic idx_lt_rank;
    logic eq;
    logic need_halve;
    rn_t  rn_case;
    logic follow_nz;
    logic follow_last;
    logic div_done;
    logic drain_empty;
    logic out_busy;
    logic eos;
  } stat_t;

endpackage

[sv/aae_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aae_if
// Handshake channels of the encoder: input items, code bytes, configuration.
// ----------------------------------------------------------------------------
interface aae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface aae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;
  logic       follow_overflow;

  modport source (output valid, output code_byte, output last_byte,
                  output follow_overflow, input ready);
  modport sink (input valid, input code_byte, input last_byte,
                input follow_overflow, output ready);
endinterface

interface aae_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aae_pkg::COUNT_W-1:0]     rescale_limit;

  modport source (output valid, output rescale_limit, input ready);
  modport sink (input valid, input rescale_limit, output ready);
endinterface

[sv/aae_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aae_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aae_div #(
  parameter int NW = 31,
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    dvd;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      rem_s;
  logic             ge;
  logic [DW:0]      rem_d;

  // trial subtract
  always_comb begin
    rem_s = {rem, dvd[NW-1]};
    ge    = rem_s >= {1'b0, dsr};
    rem_d = ge ? (rem_s - {1'b0, dsr}) : rem_s;
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[NW-2:0], ge};
      rem <= rem_d[DW-1:0];
    end
  end

  assign quotient = dvd;

endmodule

[sv/aae_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aae_datapath
// Bounds, model memories, bit packer and result buffer of the encoder.
// ----------------------------------------------------------------------------
module aae_datapath #(
  parameter int CODE_BITS     = aae_pkg::CODE_BITS_DEF,
  parameter int ALPHABET_SIZE = aae_pkg::ALPHABET_SIZE_DEF,
  parameter int FOLLOW_MAX    = aae_pkg::FOLLOW_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  aae_pkg::cmd_t               cmd,
  output aae_pkg::stat_t              stat,
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_stream,
  input  logic                        cfg_we,
  input  logic [aae_pkg::COUNT_W-1:0] cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  code_byte,
  output logic                        last_byte,
  output logic                        follow_overflow
);

  localparam int CB    = CODE_BITS;
  localparam int CW    = aae_pkg::COUNT_W;
  localparam int FW    = aae_pkg::FOLLOW_W;
  localparam int RW    = $clog2(ALPHABET_SIZE + 2);
  localparam int BW    = $clog2(ALPHABET_SIZE);
  localparam int DEPTH = ALPHABET_SIZE + 2;
  localparam int NSYM  = ALPHABET_SIZE + 1;
  localparam int PW    = CODE_BITS + 1 + CW;
  localparam int QD    = aae_pkg::RES_DEPTH;
  localparam int QA    = aae_pkg::RES_AW;

  // model memories
  logic [CW-1:0] sc_mem  [DEPTH];
  logic [CW-1:0] cum_mem [DEPTH];
  logic [7:0]    rtb_mem [DEPTH];
  logic [RW-1:0] btr_mem [ALPHABET_SIZE];
  logic [8:0]    res_mem [QD];

  logic          sc_we, cum_we, rtb_we, btr_we;
  logic [RW-1:0] sc_wa, sc_ra, cum_wa, cum_ra, rtb_wa, rtb_ra;
  logic [BW-1:0] btr_wa, btr_ra;
  logic [CW-1:0] sc_wd, cum_wd, sc_q, cum_q;
  logic [7:0]    rtb_wd, rtb_q;
  logic [RW-1:0] btr_wd, btr_q;
  logic [8:0]    res_q;

  // coder state
  logic [CB-1:0] low, high;
  logic [FW-1:0] follow;
  logic [7:0]    sbuf;
  logic [3:0]    bleft;
  logic          sticky;
  logic          bitval;
  logic          eos;
  logic [CW-1:0] limit;

  // working registers
  logic [RW-1:0] rank, idx;
  logic [CW-1:0] cum0, total, cumhi, cumlo, v, acc;
  logic [CB:0]   span;
  logic [PW-1:0] prod;
  logic [CB:0]   qhi;
  logic [7:0]    ba;
  logic [QA:0]   wptr, rptr;
  logic          flag;

  // divider
  logic          div_start, div_done;
  logic [PW-1:0] div_q;

  aae_div #(.NW(PW), .DW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (total),
    .quotient (div_q),
    .done     (div_done)
  );

  // combinational helpers
  logic [7:0]     b_cl;
  aae_pkg::rn_t   rn_case;
  logic           pb_en, pb_bit;
  logic           push;
  logic [8:0]     push_data;
  logic [7:0]     sbuf_n;
  logic [CW-1:0]  nv;
  logic [7:0]     ba_m, bb_m;
  logic [CB-1:0]  low_adj, high_adj;
  logic [CB:0]    hi_sum;

  always_comb begin
    b_cl = ({1'b0, data_byte} >= 9'(ALPHABET_SIZE)) ? 8'(ALPHABET_SIZE - 1) : data_byte;
    nv   = (sc_q + 1'b1) >> 1;
    ba_m = ({1'b0, ba} >= 9'(ALPHABET_SIZE)) ? (ba - 8'(ALPHABET_SIZE)) : ba;
    bb_m = ({1'b0, rtb_q} >= 9'(ALPHABET_SIZE)) ? (rtb_q - 8'(ALPHABET_SIZE)) : rtb_q;
    hi_sum = {1'b0, low} + qhi - 1'b1;
    sbuf_n = {pb_bit, sbuf[7:1]};
  end

  // renormalization decision and adjusted bounds
  always_comb begin
    low_adj  = low;
    high_adj = high;
    if (!high[CB-1]) begin
      rn_case = aae_pkg::RN_LOW;
    end else if (low[CB-1]) begin
      rn_case = aae_pkg::RN_HIGH;
      low_adj[CB-1]  = 1'b0;
      high_adj[CB-1] = 1'b0;
    end else if (low[CB-2] && !high[CB-2]) begin
      rn_case = aae_pkg::RN_MID;
      low_adj[CB-2]  = 1'b0;
      high_adj[CB-1] = 1'b0;
      high_adj[CB-2] = 1'b1;
    end else begin
      rn_case = aae_pkg::RN_STOP;
    end
  end

  // memory ports, packer and buffer push per operation
  always_comb begin
    sc_we  = 1'b0;  sc_wa  = idx;  sc_wd  = '0;  sc_ra  = idx;
    cum_we = 1'b0;  cum_wa = idx;  cum_wd = '0;  cum_ra = idx;
    rtb_we = 1'b0;  rtb_wa = idx;  rtb_wd = '0;  rtb_ra = idx;
    btr_we = 1'b0;  btr_wa = idx[BW-1:0];  btr_wd = '0;  btr_ra = b_cl[BW-1:0];
    pb_en  = 1'b0;  pb_bit = 1'b0;
    push   = 1'b0;  push_data = '0;
    div_start = 1'b0;
    case (cmd.op)
      aae_pkg::OP_CLR_STEP: begin
        sc_we  = 1'b1;
        sc_wd  = (idx == '0) ? '0 : CW'(1);
        cum_we = 1'b1;
        cum_wd = CW'(NSYM) - CW'(idx);
        rtb_we = 1'b1;
        rtb_wd = (idx == '0) ? 8'hFF : 8'(idx - RW'(1));
        btr_we = idx < RW'(ALPHABET_SIZE);
        btr_wd = idx + RW'(1);
      end
      aae_pkg::OP_RANK:    cum_ra = '0;
      aae_pkg::OP_GET_TOT: cum_ra = rank - RW'(1);
      aae_pkg::OP_GET_HI:  cum_ra = rank;
      aae_pkg::OP_DIV:     div_start = 1'b1;
      aae_pkg::OP_RN: begin
        pb_en  = (rn_case == aae_pkg::RN_LOW) || (rn_case == aae_pkg::RN_HIGH);
        pb_bit = rn_case == aae_pkg::RN_HIGH;
      end
      aae_pkg::OP_FOLLOW: begin
        pb_en  = 1'b1;
        pb_bit = ~bitval;
      end
      aae_pkg::OP_END_BIT: begin
        pb_en  = 1'b1;
        pb_bit = |low[CB-1:CB-2];
      end
      aae_pkg::OP_END_EMIT: begin
        push      = 1'b1;
        push_data = {1'b1, sbuf >> bleft};
      end
      aae_pkg::OP_HV_RD: sc_ra = idx;
      aae_pkg::OP_HV_WR: begin
        sc_we  = 1'b1;
        sc_wd  = nv;
        cum_we = 1'b1;
        cum_wd = acc;
      end
      aae_pkg::OP_SR_INIT: sc_ra = rank;
      aae_pkg::OP_SR_RD:   sc_ra = idx - RW'(1);
      aae_pkg::OP_SW_RD_I: rtb_ra = idx;
      aae_pkg::OP_SW_RD_R: rtb_ra = rank;
      aae_pkg::OP_SW_W1: begin
        // keep the byte at the coded rank on the read port for the second write
        rtb_ra = rank;
        rtb_we = 1'b1;
        rtb_wa = idx;
        rtb_wd = rtb_q;
        btr_we = 1'b1;
        btr_wa = ba_m[BW-1:0];
        btr_wd = rank;
      end
      aae_pkg::OP_SW_W2: begin
        rtb_we = 1'b1;
        rtb_wa = rank;
        rtb_wd = ba;
        btr_we = 1'b1;
        btr_wa = bb_m[BW-1:0];
        btr_wd = idx;
      end
      aae_pkg::OP_INC: begin
        sc_we = 1'b1;
        sc_wd = v + 1'b1;
      end
      aae_pkg::OP_CI_RD: cum_ra = idx - RW'(1);
      aae_pkg::OP_CI_WR: begin
        cum_we = 1'b1;
        cum_wd = cum_q + 1'b1;
      end
      default: ;
    endcase
    if (pb_en && bleft == 4'd1) begin
      push      = 1'b1;
      push_data = {1'b0, sbuf_n};
    end
  end

  // model memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (sc_we) sc_mem[sc_wa] <= sc_wd;
    sc_q <= sc_mem[sc_ra];
  end

  always_ff @(posedge clk) begin
    if (cum_we) cum_mem[cum_wa] <= cum_wd;
    cum_q <= cum_mem[cum_ra];
  end

  always_ff @(posedge clk) begin
    if (rtb_we) rtb_mem[rtb_wa] <= rtb_wd;
    rtb_q <= rtb_mem[rtb_ra];
  end

  always_ff @(posedge clk) begin
    if (btr_we) btr_mem[btr_wa] <= btr_wd;
    btr_q <= btr_mem[btr_ra];
  end

  // result buffer, read data held while the output register is stalled
  always_ff @(posedge clk) begin
    if (push) res_mem[wptr[QA-1:0]] <= push_data;
    if (cmd.op == aae_pkg::OP_DR_RD) res_q <= res_mem[rptr[QA-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sticky    <= 1'b0;
      eos       <= 1'b0;
      limit     <= aae_pkg::LIMIT_RESET;
      out_valid <= 1'b0;
      wptr      <= '0;
      rptr      <= '0;
    end else begin
      if (cfg_we) limit <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (push) wptr <= wptr + 1'b1;
      case (cmd.op)
        aae_pkg::OP_ACCEPT: begin
          eos  <= end_of_stream;
          wptr <= '0;
        end
        aae_pkg::OP_RN, aae_pkg::OP_END_ADD: begin
          if ((cmd.op == aae_pkg::OP_END_ADD || rn_case == aae_pkg::RN_MID) &&
              follow >= FW'(FOLLOW_MAX)) sticky <= 1'b1;
        end
        aae_pkg::OP_DR_INIT: begin
          rptr <= '0;
          if (wptr != '0) sticky <= 1'b0;
        end
        aae_pkg::OP_DR_RD:   rptr <= rptr + 1'b1;
        aae_pkg::OP_DR_LOAD: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // coder and working registers
  always_ff @(posedge clk) begin
    if (pb_en) begin
      sbuf  <= sbuf_n;
      bleft <= (bleft == 4'd1) ? 4'd8 : bleft - 1'b1;
    end
    case (cmd.op)
      aae_pkg::OP_CLR_INIT: begin
        idx    <= '0;
        low    <= '0;
        high   <= '1;
        follow <= '0;
        sbuf   <= '0;
        bleft  <= 4'd8;
      end
      aae_pkg::OP_CLR_STEP: idx <= idx + RW'(1);
      aae_pkg::OP_RANK:     rank <= eos ? RW'(NSYM) : btr_q;
      aae_pkg::OP_GET_TOT: begin
        cum0  <= cum_q;
        total <= (cum_q == '0) ? CW'(1) : cum_q;
      end
      aae_pkg::OP_GET_HI: cumhi <= cum_q;
      aae_pkg::OP_GET_LO: begin
        cumlo <= cum_q;
        span  <= {1'b0, high} - {1'b0, low} + 1'b1;
      end
      aae_pkg::OP_MUL_HI: prod <= PW'(span) * PW'(cumhi);
      aae_pkg::OP_MUL_LO: prod <= PW'(span) * PW'(cumlo);
      aae_pkg::OP_SAVE_HI: qhi <= div_q[CB:0];
      aae_pkg::OP_BOUNDS: begin
        high <= hi_sum[CB-1:0];
        low  <= low + div_q[CB-1:0];
      end
      aae_pkg::OP_RN: begin
        if (rn_case != aae_pkg::RN_STOP) begin
          low  <= {low_adj[CB-2:0], 1'b0};
          high <= {high_adj[CB-2:0], 1'b1};
        end
        if (rn_case == aae_pkg::RN_LOW || rn_case == aae_pkg::RN_HIGH)
          bitval <= rn_case == aae_pkg::RN_HIGH;
        if (rn_case == aae_pkg::RN_MID && follow < FW'(FOLLOW_MAX))
          follow <= follow + 1'b1;
      end
      aae_pkg::OP_FOLLOW: follow <= follow - 1'b1;
      aae_pkg::OP_END_ADD: begin
        if (follow < FW'(FOLLOW_MAX)) follow <= follow + 1'b1;
      end
      aae_pkg::OP_END_BIT: bitval <= |low[CB-1:CB-2];
      aae_pkg::OP_HV_INIT: begin
        idx <= RW'(NSYM);
        acc <= '0;
      end
      aae_pkg::OP_HV_WR: begin
        acc <= acc + nv;
        idx <= idx - RW'(1);
      end
      aae_pkg::OP_SR_INIT: idx <= rank;
      aae_pkg::OP_SR_V:    v <= sc_q;
      aae_pkg::OP_SR_CMP: begin
        if (sc_q == v) idx <= idx - RW'(1);
      end
      aae_pkg::OP_SW_RD_R: ba <= rtb_q;
      aae_pkg::OP_CI_RD:   idx <= idx - RW'(1);
      aae_pkg::OP_DR_INIT: flag <= sticky;
      aae_pkg::OP_DR_LOAD: begin
        code_byte       <= res_q[7:0];
        last_byte       <= res_q[8];
        follow_overflow <= flag;
      end
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    stat.clr_last    = idx == RW'(NSYM);
    stat.idx_zero    = idx == '0;
    stat.idx_lt_rank = idx < rank;
    stat.eq          = sc_q == v;
    stat.need_halve  = cum0 >= limit;
    stat.rn_case     = rn_case;
    stat.follow_nz   = follow != '0;
    stat.follow_last = follow == FW'(1);
    stat.div_done    = div_done;
    stat.drain_empty = rptr == wptr;
    stat.out_busy    = out_valid;
    stat.eos         = eos;
  end

endmodule

[sv/aae_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aae_ctrl
// Sequencer of the encoder: issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
module aae_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  aae_pkg::stat_t stat,
  output aae_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLR_INIT, S_CLR, S_IDLE, S_RANK, S_TOT, S_HI, S_LO,
    S_MUL_HI, S_DIV_HI, S_WAIT_HI, S_MUL_LO, S_DIV_LO, S_WAIT_LO,
    S_RN, S_FOL_RN, S_END_ADD, S_END_BIT, S_FOL_END, S_END_EMIT,
    S_CNT_CHK, S_HV_RD, S_HV_WR, S_SR_INIT, S_SR_V, S_SR_TEST, S_SR_CMP,
    S_SW_I, S_SW_R, S_SW_W1, S_SW_W2, S_INC, S_CI_RD, S_CI_WR,
    S_DR_INIT, S_DR_TEST, S_DR_WAIT
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  // next state and operation
  always_comb begin
    state_next = state;
    cmd.op     = aae_pkg::OP_NOP;
    unique case (state)
      S_CLR_INIT: begin
        cmd.op     = aae_pkg::OP_CLR_INIT;
        state_next = S_CLR;
      end
      S_CLR: begin
        cmd.op = aae_pkg::OP_CLR_STEP;
        if (stat.clr_last) state_next = stat.eos ? S_DR_INIT : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = aae_pkg::OP_ACCEPT;
          state_next = S_RANK;
        end
      end
      S_RANK:   begin cmd.op = aae_pkg::OP_RANK;    state_next = S_TOT;     end
      S_TOT:    begin cmd.op = aae_pkg::OP_GET_TOT; state_next = S_HI;      end
      S_HI:     begin cmd.op = aae_pkg::OP_GET_HI;  state_next = S_LO;      end
      S_LO:     begin cmd.op = aae_pkg::OP_GET_LO;  state_next = S_MUL_HI;  end
      S_MUL_HI: begin cmd.op = aae_pkg::OP_MUL_HI;  state_next = S_DIV_HI;  end
      S_DIV_HI: begin cmd.op = aae_pkg::OP_DIV;     state_next = S_WAIT_HI; end
      S_WAIT_HI: begin
        if (stat.div_done) begin
          cmd.op     = aae_pkg::OP_SAVE_HI;
          state_next = S_MUL_LO;
        end
      end
      S_MUL_LO: begin cmd.op = aae_pkg::OP_MUL_LO; state_next = S_DIV_LO;  end
      S_DIV_LO: begin cmd.op = aae_pkg::OP_DIV;    state_next = S_WAIT_LO; end
      S_WAIT_LO: begin
        if (stat.div_done) begin
          cmd.op     = aae_pkg::OP_BOUNDS;
          state_next = S_RN;
        end
      end
      // renormalize one bit per cycle, paused while pending follow bits are emitted
      S_RN: begin
        if (stat.rn_case == aae_pkg::RN_STOP) begin
          state_next = stat.eos ? S_END_ADD : S_CNT_CHK;
        end else begin
          cmd.op = aae_pkg::OP_RN;
          if (stat.rn_case != aae_pkg::RN_MID && stat.follow_nz) state_next = S_FOL_RN;
        end
      end
      S_FOL_RN: begin
        cmd.op = aae_pkg::OP_FOLLOW;
        if (stat.follow_last) state_next = S_RN;
      end
      // flush at the end of a stream
      S_END_ADD: begin cmd.op = aae_pkg::OP_END_ADD; state_next = S_END_BIT; end
      S_END_BIT: begin
        cmd.op     = aae_pkg::OP_END_BIT;
        state_next = stat.follow_nz ? S_FOL_END : S_END_EMIT;
      end
      S_FOL_END: begin
        cmd.op = aae_pkg::OP_FOLLOW;
        if (stat.follow_last) state_next = S_END_EMIT;
      end
      S_END_EMIT: begin cmd.op = aae_pkg::OP_END_EMIT; state_next = S_CLR_INIT; end
      // model update
      S_CNT_CHK: begin
        if (stat.need_halve) begin
          cmd.op     = aae_pkg::OP_HV_INIT;
          state_next = S_HV_RD;
        end else begin
          state_next = S_SR_INIT;
        end
      end
      S_HV_RD: begin cmd.op = aae_pkg::OP_HV_RD; state_next = S_HV_WR; end
      S_HV_WR: begin
        cmd.op     = aae_pkg::OP_HV_WR;
        state_next = stat.idx_zero ? S_SR_INIT : S_HV_RD;
      end
      S_SR_INIT: begin cmd.op = aae_pkg::OP_SR_INIT; state_next = S_SR_V; end
      S_SR_V:    begin cmd.op = aae_pkg::OP_SR_V;    state_next = S_SR_TEST; end
      S_SR_TEST: begin
        if (stat.idx_zero) begin
          state_next = S_SW_I;
        end else begin
          cmd.op     = aae_pkg::OP_SR_RD;
          state_next = S_SR_CMP;
        end
      end
      S_SR_CMP: begin
        cmd.op     = aae_pkg::OP_SR_CMP;
        state_next = stat.eq ? S_SR_TEST : S_SW_I;
      end
      S_SW_I: begin
        if (stat.idx_lt_rank) begin
          cmd.op     = aae_pkg::OP_SW_RD_I;
          state_next = S_SW_R;
        end else begin
          state_next = S_INC;
        end
      end
      S_SW_R:  begin cmd.op = aae_pkg::OP_SW_RD_R; state_next = S_SW_W1; end
      S_SW_W1: begin cmd.op = aae_pkg::OP_SW_W1;   state_next = S_SW_W2; end
      S_SW_W2: begin cmd.op = aae_pkg::OP_SW_W2;   state_next = S_INC;   end
      S_INC:   begin cmd.op = aae_pkg::OP_INC;     state_next = S_CI_RD; end
      S_CI_RD: begin
        if (stat.idx_zero) begin
          state_next = S_DR_INIT;
        end else begin
          cmd.op     = aae_pkg::OP_CI_RD;
          state_next = S_CI_WR;
        end
      end
      S_CI_WR: begin cmd.op = aae_pkg::OP_CI_WR; state_next = S_CI_RD; end
      // hand the buffered code bytes out
      S_DR_INIT: begin cmd.op = aae_pkg::OP_DR_INIT; state_next = S_DR_TEST; end
      S_DR_TEST: begin
        if (stat.drain_empty) begin
          state_next = S_IDLE;
        end else begin
          cmd.op     = aae_pkg::OP_DR_RD;
          state_next = S_DR_WAIT;
        end
      end
      S_DR_WAIT: begin
        if (!stat.out_busy) begin
          cmd.op     = aae_pkg::OP_DR_LOAD;
          state_next = S_DR_TEST;
        end
      end
      default: state_next = S_CLR_INIT;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/adaptive_arithmetic_encoder.sv]
`timescale 1ns / 1ps
// Work per item: the two interval divisions, the renormalized and follow bits,
// the ranks stepped in the model update, and a halving of the counts when the
// total reaches the limit; then its bytes are handed out.
// Throughput: one item at a time.
// Reset: a clearing pass loads the model; an end item runs the same pass
// before its bytes are handed out.
// ----------------------------------------------------------------------------
// adaptive_arithmetic_encoder
// Adaptive arithmetic encoder of bytes with an end symbol, packed LSB first.
// ----------------------------------------------------------------------------
module adaptive_arithmetic_encoder #(
  parameter int CODE_BITS     = aae_pkg::CODE_BITS_DEF,
  parameter int ALPHABET_SIZE = aae_pkg::ALPHABET_SIZE_DEF,
  parameter int FOLLOW_MAX    = aae_pkg::FOLLOW_MAX_DEF
) (
  input logic       clk,
  input logic       rst,
  aae_in_if.sink    in_chan,
  aae_out_if.source out_chan,
  aae_cfg_if.sink   cfg
);

  aae_pkg::cmd_t  cmd;
  aae_pkg::stat_t stat;

  // configuration is always taken
  assign cfg.ready = 1'b1;

  aae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aae_datapath #(
    .CODE_BITS     (CODE_BITS),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .FOLLOW_MAX    (FOLLOW_MAX)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .data_byte       (in_chan.data_byte),
    .end_of_stream   (in_chan.end_of_stream),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.rescale_limit),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .code_byte       (out_chan.code_byte),
    .last_byte       (out_chan.last_byte),
    .follow_overflow (out_chan.follow_overflow)
  );

`ifndef SYNTHESIS
  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input taken while an item is in work");

  // a stalled code byte holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && !out_chan.ready |=> out_chan.valid &&
    $stable(out_chan.code_byte) && $stable(out_chan.last_byte) &&
    $stable(out_chan.follow_overflow))
    else $error("code byte changed while stalled");

  // the final byte closes the item
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && out_chan.ready && out_chan.last_byte |=> !out_chan.valid)
    else $error("code byte after the final byte");
`endif

endmodule

[test/adaptive_arithmetic_encoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_arithmetic_encoder_tb
// Drives byte streams and end items through the encoder under random gaps and
// stalls, predicts every code byte with a local adaptive coder model, and
// compares each output transfer field by field in order.
// ----------------------------------------------------------------------------
module adaptive_arithmetic_encoder_tb;

  localparam int NSYM = 257;
  localparam int END_RANK = 257;
  localparam logic [16:0] TOPV = 17'h0FFFF;
  localparam logic [16:0] QTR1 = 17'h04000;
  localparam logic [16:0] HALFV = 17'h08000;
  localparam logic [16:0] QTR3 = 17'h0C000;
  localparam int FOLLOW_LIMIT = 448;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int N_RANDOM = 110;
  localparam int SETTLE_CYCLES = 1200;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
    logic       follow_overflow;
  } code_t;

  typedef struct packed {
    logic       eos;
    logic [7:0] data;
  } item_t;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   err_count;
  int   n_items;
  int   n_codes;
  int   n_streams;
  int   n_ovf;

  aae_in_if  in_chan ();
  aae_out_if out_chan ();
  aae_cfg_if cfg ();

  adaptive_arithmetic_encoder uut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg      (cfg.sink)
  );

  // coder state mirror
  logic [aae_pkg::COUNT_W-1:0] lim_m;
  logic [16:0]        lo_m, hi_m;
  int                 follow_m;
  logic [7:0]         shreg_m;
  int                 nbits_m;
  int                 b2r_m [256];
  logic [7:0]         r2b_m [NSYM+1];
  int                 freq_m [NSYM+1];
  int                 cum_m [NSYM+1];
  logic               ovf_m;
  code_t              code_q[$];
  code_t              item_codes[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic coder_clear();
    lo_m = 0;
    hi_m = TOPV;
    follow_m = 0;
    shreg_m = 0;
    nbits_m = 8;
    for (int k = 0; k < 256; k++) begin
      b2r_m[k] = k + 1;
      r2b_m[k+1] = k[7:0];
    end
    r2b_m[0] = 8'hFF;
    for (int k = 0; k <= NSYM; k++) begin
      freq_m[k] = 1;
      cum_m[k] = NSYM - k;
    end
    freq_m[0] = 0;
  endtask

  task automatic push_code(logic [7:0] v, logic lst);
    code_t c;
    c.code_byte = v;
    c.last_byte = lst;
    c.follow_overflow = 1'b0;
    if (item_codes.size() < aae_pkg::RES_DEPTH) item_codes.push_back(c);
  endtask

  task automatic shift_bit(logic b);
    shreg_m = {b, shreg_m[7:1]};
    nbits_m--;
    if (nbits_m == 0) begin
      push_code(shreg_m, 1'b0);
      nbits_m = 8;
    end
  endtask

  task automatic shift_bit_follow(logic b);
    shift_bit(b);
    while (follow_m > 0) begin
      shift_bit(~b);
      follow_m--;
    end
  endtask

  task automatic bump_follow();
    if (follow_m >= FOLLOW_LIMIT) ovf_m = 1'b1;
    else follow_m++;
  endtask

  task automatic narrow_interval(int r);
    logic [47:0] span, tot;
    span = hi_m - lo_m + 1;
    tot = cum_m[0];
    if (tot == 0) tot = 1;
    hi_m = lo_m + (span * cum_m[r-1]) / tot - 1;
    lo_m = lo_m + (span * cum_m[r]) / tot;
    forever begin
      if (hi_m < HALFV) begin
        shift_bit_follow(1'b0);
      end else if (lo_m >= HALFV) begin
        shift_bit_follow(1'b1);
        lo_m -= HALFV;
        hi_m -= HALFV;
      end else if (lo_m >= QTR1 && hi_m < QTR3) begin
        bump_follow();
        lo_m -= QTR1;
        hi_m -= QTR1;
      end else begin
        break;
      end
      lo_m = (lo_m << 1) & TOPV;
      hi_m = ((hi_m << 1) | 1) & TOPV;
    end
  endtask

  task automatic count_symbol(int r);
    int i, acc;
    logic [7:0] ba, bb;
    if (cum_m[0] >= lim_m) begin
      acc = 0;
      for (int j = NSYM; j >= 0; j--) begin
        freq_m[j] = (freq_m[j] + 1) >> 1;
        cum_m[j] = acc;
        acc += freq_m[j];
      end
    end
    i = r;
    while (i > 0 && freq_m[i] == freq_m[i-1]) i--;
    if (i < r) begin
      ba = r2b_m[i];
      bb = r2b_m[r];
      r2b_m[i] = bb;
      r2b_m[r] = ba;
      b2r_m[ba] = r;
      b2r_m[bb] = i;
    end
    freq_m[i]++;
    while (i > 0) begin
      i--;
      cum_m[i]++;
    end
  endtask

  // expected code bytes of one input item
  task automatic encode_item(item_t it);
    code_t c;
    item_codes.delete();
    if (it.eos) begin
      narrow_interval(END_RANK);
      bump_follow();
      shift_bit_follow(lo_m < QTR1 ? 1'b0 : 1'b1);
      push_code(shreg_m >> nbits_m, 1'b1);
      coder_clear();
      n_streams++;
    end else begin
      narrow_interval(b2r_m[it.data]);
      count_symbol(b2r_m[it.data] == 0 ? 0 : b2r_m[it.data]);
    end
    if (item_codes.size() > 0) begin
      if (ovf_m) n_ovf++;
      foreach (item_codes[k]) begin
        c = item_codes[k];
        c.follow_overflow = ovf_m;
        code_q.push_back(c);
      end
      ovf_m = 1'b0;
    end
  endtask

  // random stall on the code byte side
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_chan.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 3);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // compare each code byte transfer
  always @(posedge clk) begin
    code_t got, exp_c;
    if (!rst && out_chan.valid && out_chan.ready) begin
      got.code_byte = out_chan.code_byte;
      got.last_byte = out_chan.last_byte;
      got.follow_overflow = out_chan.follow_overflow;
      n_codes++;
      if (code_q.size() == 0) begin
        $display("%0t: unexpected code byte %h", $time, got);
        err_count++;
      end else begin
        exp_c = code_q.pop_front();
        if (got.code_byte !== exp_c.code_byte) begin
          $display("%0t: code_byte exp %h got %h", $time, exp_c.code_byte,
                   got.code_byte);
          err_count++;
        end
        if (got.last_byte !== exp_c.last_byte) begin
          $display("%0t: last_byte exp %b got %b", $time, exp_c.last_byte,
                   got.last_byte);
          err_count++;
        end
        if (got.follow_overflow !== exp_c.follow_overflow) begin
          $display("%0t: follow_overflow exp %b got %b", $time,
                   exp_c.follow_overflow, got.follow_overflow);
          err_count++;
        end
      end
    end
  end

  // a nonzero idle gap so the drive of the next item gets its own edge
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 1 :
        (($urandom_range(0, 11) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3));
    repeat (n) @(posedge clk);
  endtask

  // one input transfer, then its expected codes
  task automatic send_item(item_t it);
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= it.data;
    in_chan.end_of_stream <= it.eos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    in_chan.valid <= 1'b0;
    in_chan.data_byte <= $urandom();
    in_chan.end_of_stream <= $urandom();
    encode_item(it);
    n_items++;
    idle_gap();
  endtask

  task automatic write_limit(logic [aae_pkg::COUNT_W-1:0] v);
    while (code_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.rescale_limit <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    lim_m = v;
  endtask

  // random stream; biased bytes keep the model moving, runs push follow bits
  task automatic random_stream(int len);
    item_t it;
    logic [7:0] hot;
    hot = $urandom();
    for (int k = 0; k < len; k++) begin
      it.eos = 1'b0;
      case ($urandom_range(0, 3))
        0: it.data = hot;
        1: it.data = hot ^ $urandom_range(0, 3);
        default: it.data = $urandom();
      endcase
      send_item(it);
    end
    it.eos = 1'b1;
    it.data = $urandom();
    send_item(it);
  endtask

  // directed items: eos and data byte
  item_t directed_tab [20] = '{
    '{1'b1, 8'h00}, '{1'b0, 8'h00}, '{1'b0, 8'hFF}, '{1'b0, 8'h80}, '{1'b0, 8'h7F},
    '{1'b0, 8'h55}, '{1'b0, 8'hAA}, '{1'b0, 8'hFF}, '{1'b0, 8'hFF}, '{1'b0, 8'hFF},
    '{1'b0, 8'h01}, '{1'b1, 8'hFF}, '{1'b1, 8'h00}, '{1'b0, 8'h00}, '{1'b0, 8'h00},
    '{1'b0, 8'h00}, '{1'b0, 8'h00}, '{1'b0, 8'h00}, '{1'b0, 8'h00}, '{1'b1, 8'h00}
  };

  initial begin
    int remaining;
    err_count = 0;
    n_items = 0;
    n_codes = 0;
    n_streams = 0;
    n_ovf = 0;
    lim_m = aae_pkg::LIMIT_RESET;
    ovf_m = 1'b0;
    coder_clear();
    rst = 1'b1;
    in_chan.valid = 1'b0;
    in_chan.data_byte = 8'h00;
    in_chan.end_of_stream = 1'b0;
    cfg.valid = 1'b0;
    cfg.rescale_limit = aae_pkg::LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // an empty stream right after reset flushes to 0x00 and a final 0x02
    send_item(directed_tab[0]);
    if (code_q.size() != 2 || code_q[0] !== code_t'({8'h00, 1'b0, 1'b0}) ||
        code_q[1] !== code_t'({8'h02, 1'b1, 1'b0})) begin
      $display("%0t: empty stream exp 00/0/0 02/1/0 model %p", $time, code_q);
      err_count++;
    end
    for (int k = 1; k < 20; k++) send_item(directed_tab[k]);

    // low limit: counts halve before every update but the first of the stream
    write_limit(14'd258);
    random_stream(20);
    write_limit(14'd0);
    random_stream(8);
    write_limit(14'd3000);
    random_stream(40);
    // largest limit, then lowered between streams on an idle block
    write_limit(14'h3FFF);
    remaining = N_RANDOM - 68;
    while (remaining > 0) begin
      random_stream(remaining > 30 ? 30 : remaining);
      remaining -= 30;
    end
    write_limit(14'd600);
    random_stream(12);

    while (code_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items, %0d streams, %0d code bytes checked", n_items,
             n_streams, n_codes);
    $display("items with follow overflow: %0d, limits from 0 to 16383", n_ovf);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
